// ===== rtl/mcb_pkg.sv =====
// ----------------------------------------------------------------------------
// mcb_pkg
// Shared types and constants for the seek/coast/brake motor controller.
// ----------------------------------------------------------------------------
`default_nettype none

package mcb_pkg;

  // Field widths
  localparam int unsigned DUTY_W    = 8;
  localparam int unsigned TIMER_W   = 16;
  localparam int unsigned LOSS_W    = 8;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DW    = 16;
  localparam int unsigned IN_DW     = 16;
  localparam int unsigned OUT_DW    = 16;

  // Loss counter threshold: duty is forced to zero above this count
  localparam logic [LOSS_W-1:0] LOSS_LIMIT = 8'd2;

  // Saturation values
  localparam logic [TIMER_W-1:0] TIMER_MAX = 16'hFFFF;
  localparam logic [LOSS_W-1:0]  LOSS_MAX  = 8'hFF;

  // Configuration reset values
  localparam logic [TIMER_W-1:0] COAST_TICKS_RST = 16'd50;
  localparam logic [DUTY_W-1:0]  SEEK_DUTY_RST   = 8'd128;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COAST_TICKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEEK_DUTY   = 1'b1;

  // Item kinds
  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_COMMAND = 1'b1;

  // Command modes
  localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SEEK_MIN = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SEEK_MID = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SEEK_MAX = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RUN_CW   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RUN_CCW  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_6  = 3'd6;  // treated as idle
  localparam logic [MODE_W-1:0] MODE_SPARE_7  = 3'd7;  // treated as idle

  // Motor phase
  typedef enum logic [1:0] {
    PH_BRAKE = 2'd0,
    PH_COAST = 2'd1,
    PH_RUN   = 2'd2
  } phase_t;

  // One input item
  typedef struct packed {
    logic              action;
    logic [MODE_W-1:0] mode;
    logic [DUTY_W-1:0] req_duty;
    logic              limit_min_n;
    logic              limit_mid_n;
    logic              limit_max_n;
    logic              driver_ok;
  } item_t;

  // One result item
  typedef struct packed {
    logic [DUTY_W-1:0] duty_out;
    logic              direction;
    logic              coast;
    logic              driver_reset_pulse;
    logic              done_res;
  } result_t;

  // Controller state carried from item to item
  typedef struct packed {
    phase_t             phase;
    logic [TIMER_W-1:0] coast_timer;
    logic [LOSS_W-1:0]  loss_count;
    logic [DUTY_W-1:0]  duty;
    logic               direction;
    logic               coast;
  } state_t;

  // Configuration register contents
  typedef struct packed {
    logic [TIMER_W-1:0] coast_ticks;
    logic [DUTY_W-1:0]  seek_duty;
  } cfg_t;

endpackage : mcb_pkg

`default_nettype wire

// ===== rtl/dc_motor_seek_coast_brake_ctrl.sv =====
// ----------------------------------------------------------------------------
// dc_motor_seek_coast_brake_ctrl
// H-bridge DC motor controller with limit seeking, direct run, coast and brake.
// ----------------------------------------------------------------------------
// Each input transaction is a 10 ms tick (tuser = 0) or a command (tuser = 1)
// and yields exactly one result transaction. Items are captured in an input
// register, evaluated in one pass of combinational logic against the motor
// state, and the result lands in an output register that drives out_tvalid;
// one item is taken every cycle as long as the output side keeps up; a
// stalled output holds one result while a
// second item waits in the input register. Configuration writes take effect
// in the cycle after the write and should be issued only while the block is
// idle.
`default_nettype none

module dc_motor_seek_coast_brake_ctrl
  import mcb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input stream
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // [2:0] mode, [10:3] req_duty, [11] limit_min_n, [12] limit_mid_n,
  // [13] limit_max_n, [14] driver_ok, [15] zero
  input  wire logic [IN_DW-1:0]     in_tdata,
  // [0] action
  input  wire logic                 in_tuser,
  // Result stream
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // [7:0] duty_out, [8] direction, [9] coast, [10] driver_reset_pulse,
  // [11] done_res, [15:12] zero
  output logic [OUT_DW-1:0]         out_tdata,
  // Configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0]    cfg_data
);

  cfg_t    cfg;
  item_t   in_item_r;
  logic    in_valid_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t res_nxt;
  result_t out_res_r;
  logic    out_valid_r;
  logic    advance;
  item_t   in_item;

  mcb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mcb_step u_step (
    .item   (in_item_r),
    .st     (state_r),
    .cfg    (cfg),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  // Unpack the incoming transaction
  always_comb begin
    in_item.action      = in_tuser;
    in_item.mode        = in_tdata[2:0];
    in_item.req_duty    = in_tdata[10:3];
    in_item.limit_min_n = in_tdata[11];
    in_item.limit_mid_n = in_tdata[12];
    in_item.limit_max_n = in_tdata[13];
    in_item.driver_ok   = in_tdata[14];
  end

  // Handshake: evaluate the held item when the output register is free
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) in_item_r <= in_item;
  end

  // Motor state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '{phase: PH_BRAKE, coast_timer: '0, loss_count: '0,
                       duty: '0, direction: 1'b0, coast: 1'b0};
      out_valid_r <= 1'b0;
    end else begin
      if (advance) state_r <= state_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.done_res, out_res_r.driver_reset_pulse,
                       out_res_r.coast, out_res_r.direction, out_res_r.duty_out};

  // A reset pulse is only issued while a nonzero duty is driven
  a_pulse_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.driver_reset_pulse |-> out_res_r.duty_out != '0)
    else $error("reset pulse with zero duty");

  // Reaching a target or idling always leaves the bridge undriven
  a_done_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.done_res |-> out_res_r.duty_out == '0)
    else $error("done with nonzero duty");

  // Coasting and driving never overlap
  a_coast_duty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.coast |-> state_r.duty == '0)
    else $error("coast flag set while driving");

  // A held item is not dropped while the output is stalled
  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_item_r))
    else $error("input item lost during stall");

endmodule : dc_motor_seek_coast_brake_ctrl

`default_nettype wire

// ===== rtl/mcb_cfg.sv =====
// ----------------------------------------------------------------------------
// mcb_cfg
// Configuration register file: coast tick count and seek duty.
// ----------------------------------------------------------------------------
`default_nettype none

module mcb_cfg
  import mcb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0]    cfg_data,
  output cfg_t                      cfg
);

  logic [TIMER_W-1:0] coast_ticks_r;
  logic [DUTY_W-1:0]  seek_duty_r;

  // Writes are always accepted: cfg_ready is tied high
  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coast_ticks_r <= COAST_TICKS_RST;
      seek_duty_r   <= SEEK_DUTY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COAST_TICKS: coast_ticks_r <= cfg_data[TIMER_W-1:0];
        REG_SEEK_DUTY:   seek_duty_r   <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.coast_ticks = coast_ticks_r;
  assign cfg.seek_duty   = seek_duty_r;

endmodule : mcb_cfg

`default_nettype wire

// ===== rtl/mcb_step.sv =====
// ----------------------------------------------------------------------------
// mcb_step
// Next-state and result logic for one tick or command.
// ----------------------------------------------------------------------------
`default_nettype none

module mcb_step
  import mcb_pkg::*;
(
  input  wire item_t  item,
  input  wire state_t st,
  input  wire cfg_t   cfg,
  output state_t      st_nxt,
  output result_t     res
);

  always_comb begin
    state_t            s;
    logic              power;
    logic              stop;
    logic              sw_n;
    logic              pulse;
    logic              done;
    logic [DUTY_W-1:0] d;
    logic [LOSS_W-1:0] loss_inc;

    s        = st;
    power    = 1'b0;
    stop     = 1'b0;
    sw_n     = 1'b1;
    pulse    = 1'b0;
    done     = 1'b0;
    d        = item.req_duty;
    loss_inc = st.loss_count;

    if (item.action == ACT_TICK) begin
      // Tick: advance timers, drop drive after too many silent ticks
      if (st.coast_timer != TIMER_MAX) s.coast_timer = st.coast_timer + 16'd1;
      if (st.loss_count != LOSS_MAX) loss_inc = st.loss_count + 8'd1;
      s.loss_count = loss_inc;
      if (loss_inc > LOSS_LIMIT) s.duty = '0;
    end else begin
      s.loss_count = '0;
      unique case (item.mode)
        MODE_SEEK_MIN, MODE_SEEK_MID, MODE_SEEK_MAX: begin
          unique case (item.mode)
            MODE_SEEK_MIN: sw_n = item.limit_min_n;
            MODE_SEEK_MID: sw_n = item.limit_mid_n;
            default:       sw_n = item.limit_max_n;
          endcase
          if (!sw_n) begin
            done = 1'b1;
            stop = 1'b1;
          end else begin
            d           = cfg.seek_duty;
            s.direction = 1'b1;
            s.coast     = 1'b0;
            power       = 1'b1;
          end
        end
        MODE_RUN_CW, MODE_RUN_CCW: begin
          s.direction = (item.mode == MODE_RUN_CW);
          s.coast     = 1'b0;
          power       = 1'b1;
        end
        default: begin
          done = 1'b1;
          stop = 1'b1;
        end
      endcase

      // Stop: a running motor enters coast, coast ends in brake when time is up
      if (stop) begin
        s.duty = '0;
        if (s.phase == PH_RUN) begin
          s.coast       = 1'b1;
          s.phase       = PH_COAST;
          s.coast_timer = '0;
        end
        if (!(s.phase == PH_COAST && s.coast_timer < cfg.coast_ticks)) begin
          s.coast = 1'b0;
          s.phase = PH_BRAKE;
        end
      end

      // Drive: nonzero duty runs the motor, a faulted driver gets a reset pulse
      if (power) begin
        if (d == '0) begin
          s.duty = '0;
        end else begin
          pulse   = !item.driver_ok;
          s.duty  = d;
          s.phase = PH_RUN;
        end
      end
    end

    st_nxt                 = s;
    res.duty_out           = s.duty;
    res.direction          = s.direction;
    res.coast              = s.coast;
    res.driver_reset_pulse = pulse;
    res.done_res           = done;
  end

endmodule : mcb_step

`default_nettype wire

// ===== test/mcb_checker.sv =====
// ----------------------------------------------------------------------------
// mcb_checker
// Watches the configuration, input and result channels of the motor
// controller, predicts each result from its own copy of the controller state
// and compares every accepted result field by field with the oldest one due.
// ----------------------------------------------------------------------------
`default_nettype none

module mcb_checker
  import mcb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  input  wire logic                 in_tready,
  input  wire logic [IN_DW-1:0]     in_tdata,
  input  wire logic                 in_tuser,
  input  wire logic                 out_tvalid,
  input  wire logic                 out_tready,
  input  wire logic [OUT_DW-1:0]    out_tdata,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0]    cfg_data,
  output int                        fail_count,
  output int                        pending_count
);

  // Predicted controller state and register copy
  phase_t             phase;
  logic [TIMER_W-1:0] coast_timer;
  logic [LOSS_W-1:0]  loss_count;
  logic [DUTY_W-1:0]  duty_q;
  logic               dir_q;
  logic               coast_q;
  logic               pulse_now;
  logic [TIMER_W-1:0] coast_ticks_cfg;
  logic [DUTY_W-1:0]  seek_duty_cfg;

  // Bridge outputs still owed by the block, oldest first
  result_t bridge_outputs_due[$];

  // One line per mismatch, and count it
  task automatic flag_mismatch(input string what, input int unsigned got_v,
                               input int unsigned want_v);
    $display("mismatch on %s: got %0d, expected %0d (t=%0t)", what, got_v, want_v, $time);
    fail_count++;
  endtask

  // Apply a drive duty; zero only clears the duty and keeps the phase
  function automatic void drive_bridge(input logic [DUTY_W-1:0] d, input logic ok);
    if (d == '0) begin
      duty_q = '0;
      return;
    end
    if (!ok) pulse_now = 1'b1;
    duty_q = d;
    phase  = PH_RUN;
  endfunction

  // Stop: a running motor starts to coast, a coast past its time brakes
  function automatic void halt_motor(input logic ok);
    drive_bridge('0, ok);
    if (phase == PH_RUN) begin
      coast_q     = 1'b1;
      phase       = PH_COAST;
      coast_timer = '0;
    end
    if (phase == PH_COAST && coast_timer < coast_ticks_cfg) return;
    coast_q = 1'b0;
    phase   = PH_BRAKE;
  endfunction

  // Next bridge output for one tick or command
  function automatic result_t advance_motor(input item_t it);
    result_t           r;
    logic [DUTY_W-1:0] d;
    logic              power;
    logic              sw;
    logic              done;
    pulse_now = 1'b0;
    done      = 1'b0;
    power     = 1'b0;
    d         = it.req_duty;
    if (it.action == ACT_TICK) begin
      if (coast_timer != TIMER_MAX) coast_timer++;
      if (loss_count != LOSS_MAX) loss_count++;
      if (loss_count > LOSS_LIMIT) duty_q = '0;
    end else begin
      loss_count = '0;
      case (it.mode)
        MODE_SEEK_MIN, MODE_SEEK_MID, MODE_SEEK_MAX: begin
          sw = (it.mode == MODE_SEEK_MIN) ? it.limit_min_n :
               (it.mode == MODE_SEEK_MID) ? it.limit_mid_n : it.limit_max_n;
          if (!sw) begin
            done = 1'b1;
            halt_motor(it.driver_ok);
          end else begin
            d       = seek_duty_cfg;
            dir_q   = 1'b1;
            coast_q = 1'b0;
            power   = 1'b1;
          end
        end
        MODE_RUN_CW, MODE_RUN_CCW: begin
          dir_q   = (it.mode == MODE_RUN_CW);
          coast_q = 1'b0;
          power   = 1'b1;
        end
        default: begin
          done = 1'b1;
          halt_motor(it.driver_ok);
        end
      endcase
      drive_bridge(power ? d : '0, it.driver_ok);
    end
    r.duty_out           = duty_q;
    r.direction          = dir_q;
    r.coast              = coast_q;
    r.driver_reset_pulse = pulse_now;
    r.done_res           = done;
    return r;
  endfunction

  // Channel monitor: register writes, results, then new items
  always @(posedge clk) begin : watch
    item_t   it;
    result_t want;
    if (!rst_n) begin
      phase           = PH_BRAKE;
      coast_timer     = '0;
      loss_count      = '0;
      duty_q          = '0;
      dir_q           = 1'b0;
      coast_q         = 1'b0;
      pulse_now       = 1'b0;
      coast_ticks_cfg = COAST_TICKS_RST;
      seek_duty_cfg   = SEEK_DUTY_RST;
      fail_count      = 0;
      bridge_outputs_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COAST_TICKS: coast_ticks_cfg = cfg_data[TIMER_W-1:0];
          REG_SEEK_DUTY:   seek_duty_cfg   = cfg_data[DUTY_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (bridge_outputs_due.size() == 0) begin
          flag_mismatch("result with nothing due", 32'(out_tdata), 32'd0);
        end else begin
          want = bridge_outputs_due.pop_front();
          if (out_tdata[7:0] !== want.duty_out)
            flag_mismatch("duty_out", 32'(out_tdata[7:0]), 32'(want.duty_out));
          if (out_tdata[8] !== want.direction)
            flag_mismatch("direction", 32'(out_tdata[8]), 32'(want.direction));
          if (out_tdata[9] !== want.coast)
            flag_mismatch("coast", 32'(out_tdata[9]), 32'(want.coast));
          if (out_tdata[10] !== want.driver_reset_pulse)
            flag_mismatch("driver_reset_pulse", 32'(out_tdata[10]),
                          32'(want.driver_reset_pulse));
          if (out_tdata[11] !== want.done_res)
            flag_mismatch("done_res", 32'(out_tdata[11]), 32'(want.done_res));
          if (out_tdata[15:12] !== 4'd0)
            flag_mismatch("padding bits", 32'(out_tdata[15:12]), 32'd0);
        end
      end
      if (in_tvalid && in_tready) begin
        it.action      = in_tuser;
        it.mode        = in_tdata[2:0];
        it.req_duty    = in_tdata[10:3];
        it.limit_min_n = in_tdata[11];
        it.limit_mid_n = in_tdata[12];
        it.limit_max_n = in_tdata[13];
        it.driver_ok   = in_tdata[14];
        bridge_outputs_due.push_back(advance_motor(it));
      end
    end
    pending_count <= bridge_outputs_due.size();
  end

endmodule : mcb_checker

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the seek/coast/brake motor controller: directed commands over
// every mode and corner (fault pulses, zero duty, loss timeout, immediate
// brake, loss saturation, coast running out), then random tick/command
// traffic under several register settings with random idling on both streams
// and one long result-side hold. The checker beside the block does all
// comparing.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import mcb_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int BLOCK_ITEMS = 130;
  localparam int LONG_HOLD   = 300;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic [IN_DW-1:0]     in_tdata   = '0;
  logic                 in_tuser   = 1'b0;
  logic                 out_tready = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_DW-1:0]    cfg_data   = '0;
  wire logic            in_tready;
  wire logic            out_tvalid;
  wire logic [OUT_DW-1:0] out_tdata;
  wire logic            cfg_ready;

  int          fail_count;
  int          pending_count;
  int unsigned cycle_count   = 0;
  logic        calm          = 1'b1;
  int          hold_requests = 0;
  int          holds_served  = 0;
  int          ready_stall   = 0;

  dc_motor_seek_coast_brake_ctrl dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  mcb_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: short random stalls, plus a long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (ready_stall > 0) begin
      ready_stall <= ready_stall - 1;
      out_tready  <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      ready_stall  <= LONG_HOLD;
      out_tready   <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 12) begin
      ready_stall <= $urandom_range(0, 7);
      out_tready  <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic item_t make_cmd(input logic [MODE_W-1:0] mode,
                                     input logic [DUTY_W-1:0] duty,
                                     input logic lmin, input logic lmid,
                                     input logic lmax, input logic ok);
    item_t it;
    it.action      = ACT_COMMAND;
    it.mode        = mode;
    it.req_duty    = duty;
    it.limit_min_n = lmin;
    it.limit_mid_n = lmid;
    it.limit_max_n = lmax;
    it.driver_ok   = ok;
    return it;
  endfunction

  // Tick with random don't-care content
  function automatic item_t make_tick();
    item_t it;
    it        = make_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    it.action = ACT_TICK;
    return it;
  endfunction

  // Mostly meaningful traffic: run/seek commands mixed with tick runs
  function automatic item_t random_item();
    item_t             it;
    int                pick;
    logic [DUTY_W-1:0] duty;
    pick = $urandom_range(0, 99);
    if (pick < 45) return make_tick();
    pick = $urandom_range(0, 99);
    duty = (pick < 10) ? 8'd0 : (pick < 20) ? 8'd255 : 8'($urandom_range(0, 255));
    it   = make_cmd(MODE_IDLE, duty, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    $urandom_range(0, 99) < 85);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      it.mode = MODE_SEEK_MIN + 3'($urandom_range(0, 2));
      // the switch being sought reads reached fairly often
      if ($urandom_range(0, 99) < 35) begin
        case (it.mode)
          MODE_SEEK_MIN: it.limit_min_n = 1'b0;
          MODE_SEEK_MID: it.limit_mid_n = 1'b0;
          default:       it.limit_max_n = 1'b0;
        endcase
      end
    end else if (pick < 70) begin
      it.mode = ($urandom_range(0, 1) != 0) ? MODE_RUN_CW : MODE_RUN_CCW;
    end else begin
      it.mode = ($urandom_range(0, 2) == 0) ? MODE_IDLE :
                ($urandom_range(0, 1) != 0) ? MODE_SPARE_7 : MODE_SPARE_6;
    end
    return it;
  endfunction

  // Offer one item, leaving tvalid up after acceptance
  task automatic send_item(input item_t it);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < 15) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {1'b0, it.driver_ok, it.limit_max_n, it.limit_mid_n,
                  it.limit_min_n, it.req_duty, it.mode};
    in_tuser  <= it.action;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop offering and wait until every result is back
  task automatic drain(input int settle);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Write both registers back to back; only legal while idle
  task automatic set_config(input logic [TIMER_W-1:0] coast_ticks,
                            input logic [DUTY_W-1:0] seek_duty);
    cfg_index <= REG_COAST_TICKS;
    cfg_data  <= coast_ticks;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_SEEK_DUTY;
    cfg_data  <= {8'($urandom_range(0, 255)), seek_duty};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [TIMER_W-1:0] block_coast [5];
    logic [DUTY_W-1:0]  block_seek [5];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every mode at the reset register values
    send_item(make_cmd(MODE_IDLE, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1));
    send_item(make_cmd(MODE_RUN_CW, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1));
    send_item(make_cmd(MODE_RUN_CCW, 8'd1, 1'b1, 1'b1, 1'b1, 1'b0));  // fault pulse
    send_item(make_cmd(MODE_RUN_CW, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0));   // zero duty run
    send_item(make_cmd(MODE_RUN_CCW, 8'd200, 1'b1, 1'b1, 1'b1, 1'b1));
    repeat (3) send_item(make_tick());                                 // loss timeout
    send_item(make_cmd(MODE_SPARE_6, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1)); // coast
    send_item(make_tick());
    send_item(make_cmd(MODE_SEEK_MIN, 8'd3, 1'b1, 1'b0, 1'b0, 1'b1));
    send_item(make_cmd(MODE_SEEK_MIN, 8'd3, 1'b0, 1'b1, 1'b1, 1'b1));
    send_item(make_cmd(MODE_SEEK_MID, 8'd9, 1'b0, 1'b1, 1'b0, 1'b0));
    send_item(make_cmd(MODE_SEEK_MID, 8'd9, 1'b1, 1'b0, 1'b1, 1'b1));
    send_item(make_cmd(MODE_SEEK_MAX, 8'd0, 1'b0, 1'b0, 1'b1, 1'b1));
    send_item(make_cmd(MODE_SEEK_MAX, 8'd0, 1'b1, 1'b1, 1'b0, 1'b0));
    send_item(make_cmd(MODE_SPARE_7, 8'd128, 1'b1, 1'b1, 1'b1, 1'b1));
    drain(3);

    // No coast time: a stop brakes at once
    set_config(16'd0, 8'd77);
    send_item(make_cmd(MODE_RUN_CW, 8'd77, 1'b1, 1'b1, 1'b1, 1'b1));
    send_item(make_cmd(MODE_IDLE, 8'd77, 1'b1, 1'b1, 1'b1, 1'b1));
    drain(3);

    // Long coast: the loss counter saturates, then the coast time runs out
    set_config(16'd260, 8'd255);
    send_item(make_cmd(MODE_RUN_CCW, 8'd9, 1'b1, 1'b1, 1'b1, 1'b1));
    send_item(make_cmd(MODE_IDLE, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1));
    repeat (300) send_item(make_tick());
    send_item(make_cmd(MODE_IDLE, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1));
    send_item(make_cmd(MODE_SEEK_MIN, 8'd0, 1'b1, 1'b1, 1'b1, 1'b0));
    drain(3);

    // Random traffic under several settings, the last one without idling
    block_coast = '{16'd0, 16'd1, 16'd3, 16'($urandom_range(2, 12)), 16'd5};
    block_seek  = '{8'd255, 8'd0, 8'($urandom_range(1, 254)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
    for (int b = 0; b < 5; b++) begin
      set_config(block_coast[b], block_seek[b]);
      for (int i = 0; i < BLOCK_ITEMS; i++) begin
        if (b == 4) begin
          if (i == 0) calm <= 1'b1;
        end else if (i % 80 == 0) begin
          calm <= 1'b0;
        end else if (i % 80 == 60) begin
          calm <= 1'b1;
        end
        if (b == 1 && i == 30) hold_requests <= hold_requests + 1;
        send_item(random_item());
      end
      drain(3);
    end

    drain(10);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule : tb_top

`default_nettype wire
